[sv/imu_offset_calibrator_core_macros.svh]
// Assertion macros for the IMU offset calibrator.
`ifndef IMU_OFFSET_CALIBRATOR_CORE_MACROS_SVH
`define IMU_OFFSET_CALIBRATOR_CORE_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define IMUOC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a condition in the next.
`define IMUOC_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

[sv/imuoc_pkg.sv]
// Shared types and constants for the IMU offset calibrator.
package imuoc_pkg;

   localparam int AXES                = 6;
   localparam int AXIS_Z_ACCEL        = 2;
   localparam int SAMPLE_W            = 16;
   localparam int SUM_W               = 24;
   localparam int GRAVITY_W           = 15;
   localparam int CAL_SAMPLES_DEFAULT = 128;
   localparam int DATA_W              = AXES * SAMPLE_W;
   localparam int RSP_USER_W          = 2;

   localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 15'd16383;

   // request tuser codes
   localparam logic OP_SAMPLE    = 1'b0;
   localparam logic OP_CAL_BEGIN = 1'b1;

   // response tuser bit positions
   localparam int RSP_ACCUMULATED = 0;
   localparam int RSP_CAL_DONE    = 1;

   // run, then three steps to turn the sums into offsets
   typedef enum logic [3:0] {
      ST_RUN = 4'b0001,
      ST_ABS = 4'b0010,
      ST_MUL = 4'b0100,
      ST_FIX = 4'b1000
   } state_type;

endpackage

[sv/imu_offset_calibrator_core.sv]
// IMU offset calibrator: offset removal and calibration by averaging.
//
// Request channel (req_): one word per six-axis sample. req_tdata holds the
// raw accel x/y/z and gyro x/y/z readings, req_tuser = 1 begins a calibration
// (the sample fields are then ignored and a zero result is returned).
// Response channel (rsp_): one word per request word, the readings minus the
// stored offsets, plus flags for "added to the sums" and "offsets updated".
// csr_wr_en/csr_wr_data load the z-axis gravity count (reset 16383).
//
// rsp_tvalid rises in the cycle after a request is accepted; one word per cycle
// is taken while the response register is empty or being drained. When the
// word that ends a calibration is taken, req_tready is low in ST_ABS, ST_MUL
// and ST_FIX while the six sums become offsets (magnitude, reciprocal multiply,
// sign and gravity fix-up), so the following word sees the new offsets.
// A stalled response holds its word and blocks new requests.
// Reset clears sums, offsets, the sample count and the calibrating flag.
`include "imu_offset_calibrator_core_macros.svh"

module imu_offset_calibrator_core import imuoc_pkg::*; #(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
   input  logic [DATA_W-1:0]     req_tdata,
   // operation
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   output logic [DATA_W-1:0]     rsp_tdata,
   // accumulated, calibration_done
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [GRAVITY_W-1:0]  csr_wr_data
);

   localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
   localparam int SHIFT   = SUM_W + $clog2(CAL_SAMPLES);
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + longint'(CAL_SAMPLES) - 64'd1) / longint'(CAL_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   state_type state_ff, state_in;

   logic [GRAVITY_W-1:0]  gravity_ff;
   logic [SUM_W-1:0]      sums_ff    [AXES];
   logic [SUM_W-1:0]      sums_in    [AXES];
   logic [SAMPLE_W-1:0]   offsets_ff [AXES];
   logic [SAMPLE_W-1:0]   offsets_in [AXES];
   logic [SUM_W-1:0]      mag_ff     [AXES];
   logic [SUM_W-1:0]      mag_in     [AXES];
   logic                  neg_ff     [AXES];
   logic                  neg_in     [AXES];
   logic [PROD_W-1:0]     prod_ff    [AXES];
   logic [PROD_W-1:0]     prod_in    [AXES];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  calibrating_ff, calibrating_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                  accept;
   logic                  last_sample;
   logic [SAMPLE_W-1:0]   corr [AXES];
   logic [SUM_W-1:0]      quot [AXES];
   logic [SUM_W-1:0]      sq   [AXES];

   assign req_tready = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign last_sample = (req_tuser[0] == OP_SAMPLE) && calibrating_ff
                        && (cnt_ff == CNT_W'(1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         corr[i] = req_tdata[i*SAMPLE_W +: SAMPLE_W] - offsets_ff[i];
         quot[i] = SUM_W'(prod_ff[i] >> SHIFT);
         sq[i]   = neg_ff[i] ? (SUM_W'(0) - quot[i]) : quot[i];
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      calibrating_in = calibrating_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      for (int i = 0; i < AXES; i++) begin
         sums_in[i]    = sums_ff[i];
         offsets_in[i] = offsets_ff[i];
         mag_in[i]     = mag_ff[i];
         neg_in[i]     = neg_ff[i];
         prod_in[i]    = prod_ff[i];
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               if (req_tuser[0] == OP_CAL_BEGIN) begin
                  rsp_data_in    = '0;
                  rsp_user_in    = '0;
                  cnt_in         = CNT_W'(CAL_SAMPLES);
                  calibrating_in = 1'b1;
                  for (int i = 0; i < AXES; i++) begin
                     sums_in[i] = '0;
                  end
               end else begin
                  for (int i = 0; i < AXES; i++) begin
                     rsp_data_in[i*SAMPLE_W +: SAMPLE_W] = corr[i];
                  end
                  rsp_user_in                  = '0;
                  rsp_user_in[RSP_ACCUMULATED] = calibrating_ff;
                  rsp_user_in[RSP_CAL_DONE]    = last_sample;
                  if (calibrating_ff) begin
                     cnt_in = cnt_ff - CNT_W'(1);
                     for (int i = 0; i < AXES; i++) begin
                        sums_in[i] = sums_ff[i]
                                     + {{(SUM_W-SAMPLE_W){corr[i][SAMPLE_W-1]}}, corr[i]};
                     end
                  end
                  if (last_sample) begin
                     calibrating_in = 1'b0;
                     state_in       = ST_ABS;
                  end
               end
            end
         end
         ST_ABS: begin
            for (int i = 0; i < AXES; i++) begin
               neg_in[i] = sums_ff[i][SUM_W-1];
               mag_in[i] = sums_ff[i][SUM_W-1] ? (SUM_W'(0) - sums_ff[i]) : sums_ff[i];
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // divide by CAL_SAMPLES as multiply by a rounded-up reciprocal
            for (int i = 0; i < AXES; i++) begin
               prod_in[i] = PROD_W'(mag_ff[i]) * PROD_W'(RECIP);
            end
            state_in = ST_FIX;
         end
         ST_FIX: begin
            for (int i = 0; i < AXES; i++) begin
               if (i == AXIS_Z_ACCEL) begin
                  offsets_in[i] = SAMPLE_W'(sq[i] - SUM_W'(gravity_ff));
               end else begin
                  offsets_in[i] = SAMPLE_W'(sq[i]);
               end
            end
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         gravity_ff     <= GRAVITY_RESET;
         cnt_ff         <= '0;
         calibrating_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            sums_ff[i]    <= '0;
            offsets_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         calibrating_ff <= calibrating_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            gravity_ff <= csr_wr_data;
         end
         for (int i = 0; i < AXES; i++) begin
            sums_ff[i]    <= sums_in[i];
            offsets_ff[i] <= offsets_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      for (int i = 0; i < AXES; i++) begin
         mag_ff[i]  <= mag_in[i];
         neg_ff[i]  <= neg_in[i];
         prod_ff[i] <= prod_in[i];
      end
   end

   `IMUOC_ASSERT(a_cal_has_count, clock, reset, !calibrating_ff || (cnt_ff != '0), "calibrating with zero samples left")
   `IMUOC_ASSERT_NEXT(a_done_starts_div, clock, reset, accept && last_sample, (state_ff == ST_ABS) && !calibrating_ff && rsp_user_ff[RSP_CAL_DONE], "end of calibration did not start offset update")
   `IMUOC_ASSERT_NEXT(a_abs_to_mul, clock, reset, state_ff == ST_ABS, state_ff == ST_MUL, "offset update skipped multiply step")
   `IMUOC_ASSERT_NEXT(a_mul_to_fix, clock, reset, state_ff == ST_MUL, state_ff == ST_FIX, "offset update skipped fix-up step")

endmodule

[test/imu_offset_calibrator_checker.sv]
// Checker for the IMU offset calibrator: tracks offsets and sums, checks every response word.
`timescale 1ns / 1ps

module imu_offset_calibrator_checker import imuoc_pkg::*; #(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
   input  logic [DATA_W-1:0]     req_tdata,
   // operation
   input  logic [0:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  logic [DATA_W-1:0]     rsp_tdata,
   // accumulated, calibration_done
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [GRAVITY_W-1:0]  csr_wr_data,
   output int                    fail_count,
   output int                    pending_words,
   output int                    calibrations_seen
);

   typedef struct packed {
      logic                               cal_done;
      logic                               accumulated;
      logic [AXES-1:0][SAMPLE_W-1:0]      axis;
   } corrected_word_type;

   logic signed [SUM_W-1:0]    axis_sum [AXES];
   logic        [SAMPLE_W-1:0] axis_offset [AXES];
   logic        [7:0]          samples_to_go;
   logic                       calibrating;
   logic        [GRAVITY_W-1:0] gravity;

   corrected_word_type corrected_q [$];
   int                 words_checked = 0;

   initial begin
      fail_count        = 0;
      pending_words     = 0;
      calibrations_seen = 0;
   end

   task automatic report_fail(input string what);
      $display("checker: response word %0d: %s", words_checked, what);
      fail_count++;
   endtask

   function automatic string axis_label(input int a);
      case (a)
         0:       return "accel_x";
         1:       return "accel_y";
         2:       return "accel_z";
         3:       return "gyro_x";
         4:       return "gyro_y";
         default: return "gyro_z";
      endcase
   endfunction

   // Advances the calibration state by one request word and returns its response.
   function automatic corrected_word_type correct_word(input logic op,
                                                       input logic [DATA_W-1:0] raw);
      corrected_word_type res;
      int                 mean;
      res = '0;
      if (op == OP_CAL_BEGIN) begin
         for (int a = 0; a < AXES; a++) axis_sum[a] = '0;
         samples_to_go = 8'(CAL_SAMPLES);
         calibrating   = 1'b1;
         return res;
      end
      for (int a = 0; a < AXES; a++)
         res.axis[a] = raw[a*SAMPLE_W +: SAMPLE_W] - axis_offset[a];
      if (calibrating) begin
         res.accumulated = 1'b1;
         for (int a = 0; a < AXES; a++)
            axis_sum[a] = axis_sum[a] + {{(SUM_W-SAMPLE_W){res.axis[a][SAMPLE_W-1]}},
                                         res.axis[a]};
         samples_to_go = samples_to_go - 8'd1;
         if (samples_to_go == 8'd0) begin
            // new offsets only apply from the next word on
            for (int a = 0; a < AXES; a++) begin
               mean = int'(axis_sum[a]) / CAL_SAMPLES;
               if (a == AXIS_Z_ACCEL) mean = mean - int'(gravity);
               axis_offset[a] = SAMPLE_W'(mean);
            end
            calibrating  = 1'b0;
            res.cal_done = 1'b1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      corrected_word_type want;
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            axis_sum[a]    = '0;
            axis_offset[a] = '0;
         end
         samples_to_go = '0;
         calibrating   = 1'b0;
         gravity       = GRAVITY_RESET;
         corrected_q.delete();
      end else begin
         if (csr_wr_en) gravity = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (corrected_q.size() == 0) begin
               report_fail($sformatf("no word expected, got data %h user %b",
                                     rsp_tdata, rsp_tuser));
            end else begin
               want = corrected_q.pop_front();
               for (int a = 0; a < AXES; a++)
                  if (rsp_tdata[a*SAMPLE_W +: SAMPLE_W] !== want.axis[a])
                     report_fail($sformatf("%s got %h expected %h", axis_label(a),
                                           rsp_tdata[a*SAMPLE_W +: SAMPLE_W], want.axis[a]));
               if (rsp_tuser[RSP_ACCUMULATED] !== want.accumulated)
                  report_fail($sformatf("accumulated got %b expected %b",
                                        rsp_tuser[RSP_ACCUMULATED], want.accumulated));
               if (rsp_tuser[RSP_CAL_DONE] !== want.cal_done)
                  report_fail($sformatf("calibration_done got %b expected %b",
                                        rsp_tuser[RSP_CAL_DONE], want.cal_done));
               if (want.cal_done) calibrations_seen++;
            end
            words_checked++;
         end
         if (req_tvalid && req_tready)
            corrected_q.push_back(correct_word(req_tuser[0], req_tdata));
      end
      pending_words = corrected_q.size();
   end

endmodule

[test/tb_imu_offset_calibrator_core.sv]
// Testbench top for the IMU offset calibrator: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_imu_offset_calibrator_core import imuoc_pkg::*;;

   localparam int CAL_LEN      = CAL_SAMPLES_DEFAULT;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata   = '0;
   logic [0:0]            req_tuser   = OP_SAMPLE;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [GRAVITY_W-1:0]  csr_wr_data = '0;

   int fail_count;
   int pending_words;
   int calibrations_seen;
   int cycles      = 0;
   int words_sent  = 0;
   int cal_starts  = 0;
   bit stall_on    = 1'b0;
   bit hold_req    = 1'b0;
   int bias [AXES];
   int gravity_picks [4];

   always #4 clock = ~clock;

   imu_offset_calibrator_core #(.CAL_SAMPLES(CAL_LEN)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   imu_offset_calibrator_checker #(.CAL_SAMPLES(CAL_LEN)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .pending_words     (pending_words),
      .calibrations_seen (calibrations_seen)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", CYCLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: short random stalls, or one long hold-off when asked.
   initial begin
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Sensor-like word around the current bias, or fully random when wild.
   function automatic logic [DATA_W-1:0] make_sample(input bit wild);
      logic [DATA_W-1:0] word;
      for (int a = 0; a < AXES; a++)
         word[a*SAMPLE_W +: SAMPLE_W] = wild ? SAMPLE_W'($urandom)
                                             : SAMPLE_W'(bias[a] + int'($urandom_range(0, 64)) - 32);
      return word;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with valid still high.
   task automatic send_word(input logic op, input logic [DATA_W-1:0] data);
      int gap;
      gap = (stall_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (op == OP_CAL_BEGIN) cal_starts++;
      @(negedge clock);
   endtask

   task automatic send_samples(input int count, input bit wild_only);
      repeat (count) send_word(OP_SAMPLE, make_sample(wild_only || $urandom_range(0, 3) == 0));
   endtask

   // Let every outstanding word come back, plus the offset fix-up time.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes with zero offsets, begin with junk fields, restart
      send_word(OP_SAMPLE, {AXES{16'h8000}});
      send_word(OP_SAMPLE, {AXES{16'h7fff}});
      send_word(OP_SAMPLE, {AXES{16'hffff}});
      send_word(OP_SAMPLE, {AXES{16'h0000}});
      send_word(OP_SAMPLE, {3{16'h5555, 16'haaaa}});
      send_word(OP_CAL_BEGIN, '1);
      send_word(OP_SAMPLE, {AXES{16'h7fff}});
      send_word(OP_SAMPLE, {AXES{16'h8000}});
      send_word(OP_SAMPLE, {AXES{16'h0001}});
      send_word(OP_CAL_BEGIN, {$urandom, $urandom, $urandom});
      send_word(OP_SAMPLE, {AXES{16'hffff}});
      send_word(OP_SAMPLE, {3{16'haaaa, 16'h5555}});

      gravity_picks[0] = 32767;
      gravity_picks[1] = 0;
      gravity_picks[2] = $urandom_range(1, 32766);
      gravity_picks[3] = GRAVITY_RESET;

      for (int phase = 0; phase < 4; phase++) begin
         settle();
         stall_on = (phase < 3);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= GRAVITY_W'(gravity_picks[phase]);
         @(negedge clock);
         csr_wr_en <= 1'b0;

         for (int a = 0; a < AXES; a++) bias[a] = int'($urandom_range(0, 2000)) - 1000;
         bias[AXIS_Z_ACCEL] = gravity_picks[phase] + int'($urandom_range(0, 400)) - 200;

         // stray samples, then a calibration cut short by a second begin
         send_samples($urandom_range(5, 15), 1'b1);
         if (phase == 1) hold_req = 1'b1;
         send_word(OP_CAL_BEGIN, {$urandom, $urandom, $urandom});
         send_samples($urandom_range(1, 30), 1'b0);
         send_word(OP_CAL_BEGIN, {$urandom, $urandom, $urandom});
         send_samples(CAL_LEN, 1'b0);
         // words after the update see the new offsets
         send_samples($urandom_range(8, 16), 1'b0);
      end

      settle();
      $display("tb: %0d words sent, %0d calibration starts, %0d calibrations completed",
               words_sent, cal_starts, calibrations_seen);
      $display("tb: gravity counts 32767, 0, %0d and 16383; one %0d-cycle receiver hold-off",
               gravity_picks[2], HOLD_CYCLES);
      if (fail_count == 0 && pending_words == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/imuoc_pkg.sv
sv/imu_offset_calibrator_core.sv
test/imu_offset_calibrator_checker.sv
test/tb_imu_offset_calibrator_core.sv
